FILE: sv/acar_pkg.sv
// ----------------------------------------------------------------------------
// acar_pkg
// Shared types and constants for the age-replacement associative cache.
// ----------------------------------------------------------------------------
package acar_pkg;

    localparam int ENTRIES  = 8;
    localparam int KEY_BITS = 64;
    localparam int AGE_BITS = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W   = 3;
    localparam int DATA_W   = 32;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [KEY_BITS-1:0] ckey_t;
    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [DATA_W-1:0]   data_t;

    // Search record handed from cell to cell
    typedef struct packed {
        logic  mhit;
        idx_t  midx;
        data_t mdata;
        logic  ffree;
        idx_t  fidx;
        age_t  oage;
        idx_t  oidx;
    } rec_t;

    // Write command broadcast to every cell
    typedef struct packed {
        logic  we;
        logic  fill;
        idx_t  widx;
        ckey_t wkey;
        data_t wdata;
    } wr_t;

    function automatic logic [SLOT_W-1:0] to_slot(idx_t idx);
        logic [31:0] t;
        t = 32'(idx);
        return t[SLOT_W-1:0];
    endfunction

endpackage

FILE: sv/assoc_cache_age_replace_unit.sv
// ----------------------------------------------------------------------------
// assoc_cache_age_replace_unit
// Fully associative cache with age-based replacement, built as a chain of
// slot cells through which a search record walks one slot per cycle.
// ----------------------------------------------------------------------------
// One item at a time: a new item is accepted only while busy is low, after the search
//   record has walked the whole slot chain and the write has been applied.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset clears all valid bits and ages at once; keys and data are not reset.
module assoc_cache_age_replace_unit
    import acar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [63:0]       key,
    input  logic [31:0]       payload,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic [31:0]       data_out
);

    logic  busy_reg, launch_reg, done_reg;
    logic  kind_reg;
    ckey_t key_reg;
    data_t pay_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    data_t             dout_reg;

    logic [ENTRIES:0] tok;
    rec_t             rec [ENTRIES+1];
    wr_t              wr;
    logic             accept;
    logic             fin;
    rec_t             res;
    idx_t             vidx;

    assign accept = start && !busy_reg;
    assign fin    = tok[ENTRIES];
    assign res    = rec[ENTRIES];

    // Seed record for the head of the chain
    assign tok[0] = launch_reg;
    assign rec[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            acar_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (idx_t'(g)),
                .skey    (key_reg),
                .tok_in  (tok[g]),
                .rec_in  (rec[g]),
                .wr      (wr),
                .tok_out (tok[g+1]),
                .rec_out (rec[g+1])
            );
        end
    endgenerate

    // Pick the write slot: match, else lowest free, else oldest
    always_comb
    begin
        if (res.mhit)
        begin
            vidx = res.midx;
        end
        else if (res.ffree)
        begin
            vidx = res.fidx;
        end
        else
        begin
            vidx = res.oidx;
        end
        wr.we    = fin && kind_reg;
        wr.fill  = !res.mhit;
        wr.widx  = vidx;
        wr.wkey  = key_reg;
        wr.wdata = pay_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            launch_reg <= accept;
            done_reg   <= fin;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Hold the item and register the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= key[KEY_BITS-1:0];
            pay_reg  <= payload;
        end
        if (fin)
        begin
            hit_reg <= res.mhit;
            if (kind_reg)
            begin
                slot_reg <= to_slot(vidx);
                dout_reg <= '0;
            end
            else
            begin
                slot_reg <= res.mhit ? to_slot(res.midx) : '0;
                dout_reg <= res.mhit ? res.mdata : '0;
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign hit      = hit_reg;
    assign slot     = slot_reg;
    assign data_out = dout_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> busy_reg)
        else $error("walk finished with no item");
    a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(fin))
        else $error("done without finished walk");
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> launch_reg && busy_reg)
        else $error("accepted item not launched");
`endif

endmodule

FILE: sv/acar_cell.sv
// ----------------------------------------------------------------------------
// acar_cell
// One cache slot: holds valid, key, data and age, folds itself into the
// passing search record and applies broadcast writes and ageing.
// ----------------------------------------------------------------------------
module acar_cell
    import acar_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  idx_t  idx,
    input  ckey_t skey,
    input  logic  tok_in,
    input  rec_t  rec_in,
    input  wr_t   wr,
    output logic  tok_out,
    output rec_t  rec_out
);

    logic  valid_reg, valid_next;
    age_t  age_reg, age_next;
    ckey_t key_reg;
    data_t data_reg;
    logic  tok_reg;
    rec_t  rec_reg, rec_next;

    // Fold this slot into the search record
    always_comb
    begin
        rec_next = rec_in;
        if (!rec_in.mhit && valid_reg && key_reg == skey)
        begin
            rec_next.mhit  = 1'b1;
            rec_next.midx  = idx;
            rec_next.mdata = data_reg;
        end
        if (!rec_in.ffree && !valid_reg)
        begin
            rec_next.ffree = 1'b1;
            rec_next.fidx  = idx;
        end
        if (age_reg > rec_in.oage)
        begin
            rec_next.oage = age_reg;
            rec_next.oidx = idx;
        end
    end

    // Write and age: written slot restarts at 1; other valid slots age on each write
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (wr.we)
        begin
            if (wr.widx == idx)
            begin
                valid_next = 1'b1;
                age_next   = age_t'(1);
            end
            else if (valid_reg && age_reg != '1)
            begin
                age_next = age_reg + age_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            tok_reg   <= tok_in;
        end
    end

    // Hold slot contents and the travelling record
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (wr.we && wr.widx == idx)
        begin
            data_reg <= wr.wdata;
            if (wr.fill)
            begin
                key_reg <= wr.wkey;
            end
        end
    end

    assign tok_out = tok_reg;
    assign rec_out = rec_reg;

endmodule
